// ===== rtl/sacl_pkg.sv =====
// shared types and constants for the set-associative cache simulator with lru replacement
// no dependencies; used by every module of the block
`default_nettype none

package sacl_pkg;

  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;

  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 32;
  localparam int AGE_W        = 32;
  localparam int CNT_W        = 32;
  localparam int WAY_IDX_W    = 4;
  localparam int VICTIM_W     = 3;
  localparam int SET_BITS_W   = 4;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd4;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_STORE  = 2'd1,
    REQ_MODIFY = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_BLOCK_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic                hit;
    logic                miss;
    logic                eviction;
    logic                modify_hit;
    logic [VICTIM_W-1:0] victim_way;
    logic [CNT_W-1:0]    hit_total;
    logic [CNT_W-1:0]    miss_total;
    logic [CNT_W-1:0]    eviction_total;
  } out_t;

  // lookup verdict handed from the way selector to the controller
  typedef struct packed {
    logic                 hit;
    logic                 evict;
    logic [WAY_IDX_W-1:0] way;
  } way_sel_t;

endpackage

`default_nettype wire

// ===== rtl/sacl_set_ram.sv =====
// set memory: one row per set holding valid bits, tags and age stamps of all ways
// one write port, one read port with registered read data; uses sacl_pkg
`default_nettype none

module sacl_set_ram #(
  parameter int ADDR_W = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int DATA_W = sacl_pkg::MAX_WAYS_DEF * (1 + sacl_pkg::TAG_W + sacl_pkg::AGE_W)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/sacl_way_sel.sv =====
// way selector: parallel tag match, first free way and lru victim over one set row
// purely combinational; uses sacl_pkg
`default_nettype none

module sacl_way_sel #(
  parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
  input  logic [MAX_WAYS-1:0]                       use_mask,
  input  logic [MAX_WAYS-1:0]                       valid,
  input  logic [MAX_WAYS-1:0][sacl_pkg::TAG_W-1:0] tags,
  input  logic [MAX_WAYS-1:0][sacl_pkg::AGE_W-1:0] ages,
  input  logic [sacl_pkg::TAG_W-1:0]                tag,
  output sacl_pkg::way_sel_t                        sel
);

  import sacl_pkg::*;

  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic [MAX_WAYS-1:0] lru_vec;

  function automatic logic [WAY_IDX_W-1:0] first_set(input logic [MAX_WAYS-1:0] v);
    logic [WAY_IDX_W-1:0] r;
    r = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (v[j]) begin
        r = WAY_IDX_W'(j);
      end
    end
    return r;
  endfunction

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      hit_vec[j]  = use_mask[j] & valid[j] & (tags[j] == tag);
      free_vec[j] = use_mask[j] & ~valid[j];
    end
  end

  // way j is the victim if it is strictly older than every lower way in use
  // and no younger than every higher way in use (lowest way wins ties)
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      lru_vec[j] = use_mask[j];
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (i != j && use_mask[i]) begin
          if (i < j) begin
            lru_vec[j] = lru_vec[j] & (ages[j] < ages[i]);
          end else begin
            lru_vec[j] = lru_vec[j] & (ages[j] <= ages[i]);
          end
        end
      end
    end
  end

  always_comb begin
    sel.hit   = |hit_vec;
    sel.evict = ~(|hit_vec) & ~(|free_vec);
    if (|hit_vec) begin
      sel.way = first_set(hit_vec);
    end else if (|free_vec) begin
      sel.way = first_set(free_vec);
    end else begin
      sel.way = first_set(lru_vec);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_cache_lru_sim.sv =====
// Set-associative cache simulator with lru replacement. In each access the accepting
// cycle reads the set's row (valid bits, tags, age stamps of all ways) from the set
// memory, and the lookup state then matches tags, picks the hit, free or lru way, writes
// the row back and loads the result register. The set memory has one port per direction,
// and no new access is taken until the row is written back; an access waits in the lookup
// state while an earlier result has not been taken. Request kind 3 is accepted and dropped
// with no result. After reset a clearing pass zeroes every row of the memory; in_ready
// stays low until it is done, while configuration writes are taken at any time.
// depends on sacl_pkg, sacl_set_ram and sacl_way_sel
`default_nettype none

module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sacl_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sacl_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);

  import sacl_pkg::*;

  localparam int SET_W = MAX_SET_BITS;
  localparam int ROW_W = MAX_WAYS * (1 + TAG_W + AGE_W);

  // configuration
  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [BLOCK_BITS_W-1:0] block_bits_r;
  logic [WAYS_W-1:0]       ways_r;
  logic [SET_BITS_W-1:0]   s_eff;
  logic [WAYS_W:0]         e_eff;
  logic [SET_W-1:0]        set_mask;
  logic [MAX_WAYS-1:0]     use_mask;

  // control
  state_t           state_r, state_nxt;
  logic [SET_W-1:0] clr_addr_r;
  logic             advance;
  logic             take_req;

  // access in flight
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag_val;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic              modify_r;

  // set memory
  logic             ram_we;
  logic             ram_re;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] row_new;

  logic [MAX_WAYS-1:0]             rd_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0]  rd_age;
  logic [MAX_WAYS-1:0]             wr_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  wr_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0]  wr_age;

  way_sel_t sel;

  // stamps and totals
  logic [AGE_W-1:0] stamp_r, stamp_nxt;
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0] evict_cnt_r, evict_cnt_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  out_t out_nxt;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [1:0]       inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, v} + {{(CNT_W - 1){1'b0}}, inc};
    return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_r       <= WAYS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits_r   <= cfg_data[SET_BITS_W-1:0];
        CFG_BLOCK_BITS:  block_bits_r <= cfg_data[BLOCK_BITS_W-1:0];
        CFG_WAYS_IN_USE: ways_r       <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp set bits and way count to what the memory holds (a way count of zero counts as one)
  always_comb begin
    s_eff = (32'(set_bits_r) > 32'(MAX_SET_BITS)) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_r;
    if (ways_r == '0) begin
      e_eff = (WAYS_W + 1)'(1);
    end else if (32'(ways_r) > 32'(MAX_WAYS)) begin
      e_eff = (WAYS_W + 1)'(MAX_WAYS);
    end else begin
      e_eff = {1'b0, ways_r};
    end
    for (int k = 0; k < SET_W; k++) begin
      set_mask[k] = 32'(s_eff) > 32'(k);
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      use_mask[j] = 32'(e_eff) > 32'(j);
    end
  end

  assign shifted = in_data.address >> block_bits_r;
  assign set_idx = shifted[SET_W-1:0] & set_mask;
  assign tag_val = shifted >> s_eff;
  assign take_req = in_valid && (in_data.req_type != REQ_NONE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take_req) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs; the write-back and the next read never share a cycle, so no forwarding
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = row_new;
    advance   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_re   = take_req;
      end
      ST_LOOKUP: begin
        advance = !out_valid_r || out_ready;
        ram_we  = advance;
      end
      default: ;
    endcase
  end

  sacl_set_ram #(
    .ADDR_W(SET_W),
    .DATA_W(ROW_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(set_idx),
    .rdata(rd_row)
  );

  assign rd_valid = rd_row[ROW_W-1 -: MAX_WAYS];
  assign rd_tag   = rd_row[MAX_WAYS*(TAG_W+AGE_W)-1 -: MAX_WAYS*TAG_W];
  assign rd_age   = rd_row[MAX_WAYS*AGE_W-1:0];

  sacl_way_sel #(
    .MAX_WAYS(MAX_WAYS)
  ) u_way_sel (
    .use_mask(use_mask),
    .valid   (rd_valid),
    .tags    (rd_tag),
    .ages    (rd_age),
    .tag     (tag_r),
    .sel     (sel)
  );

  // refresh the chosen way; a miss also installs the new tag
  always_comb begin
    wr_valid = rd_valid;
    wr_tag   = rd_tag;
    wr_age   = rd_age;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (32'(sel.way) == 32'(j)) begin
        wr_valid[j] = 1'b1;
        wr_age[j]   = stamp_r;
        if (!sel.hit) begin
          wr_tag[j] = tag_r;
        end
      end
    end
    row_new = {wr_valid, wr_tag, wr_age};
  end

  always_comb begin
    stamp_nxt     = stamp_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    if (advance) begin
      stamp_nxt     = stamp_r + 1'b1;
      hit_cnt_nxt   = sat_add(hit_cnt_r, {1'b0, modify_r} + {1'b0, sel.hit});
      miss_cnt_nxt  = sat_add(miss_cnt_r, {1'b0, ~sel.hit});
      evict_cnt_nxt = sat_add(evict_cnt_r, {1'b0, sel.evict});
    end
  end

  always_comb begin
    out_nxt.hit            = sel.hit;
    out_nxt.miss           = ~sel.hit;
    out_nxt.eviction       = sel.evict;
    out_nxt.modify_hit     = modify_r;
    out_nxt.victim_way     = sel.way[VICTIM_W-1:0];
    out_nxt.hit_total      = hit_cnt_nxt;
    out_nxt.miss_total     = miss_cnt_nxt;
    out_nxt.eviction_total = evict_cnt_nxt;
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      stamp_r     <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stamp_r     <= stamp_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      set_r    <= set_idx;
      tag_r    <= tag_val;
      modify_r <= (in_data.req_type == REQ_MODIFY);
    end
    if (advance) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_hit_xor_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.hit, out_data.miss}))
    else $error("result is not exactly one of hit and miss");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.eviction |-> out_data.miss)
    else $error("eviction reported on a hit");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready && !ram_re)
    else $error("access taken during the clearing pass");

  a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished lookup did not present a result");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> stamp_r == $past(stamp_r) + 1'b1)
    else $error("access stamp did not advance by one per access");

endmodule

`default_nettype wire
